### design/umpe_pkg.sv
// Shared types, codes and constants of the uniformized matrix power engine.
package umpe_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_LOAD_RATE = 2'd0,
    CMD_LOAD_STAT = 2'd1,
    CMD_QUERY_POW = 2'd2,
    CMD_QUERY_MU  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_PROB = 2'd1,
    ST_ZERO_MU  = 2'd2
  } status_t;

  // Result source select
  typedef enum logic [2:0] {
    RES_ZERO = 3'd0,
    RES_MU   = 3'd1,
    RES_UNIT = 3'd2,
    RES_STAT = 3'd3,
    RES_TAB  = 3'd4
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MU_RD,
    S_MU_ACC,
    S_MU_END,
    S_DIV_RD,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_END,
    S_ANSWER,
    S_MAC_RUN,
    S_MAC_DRAIN,
    S_STAT_WAIT,
    S_TAB_WAIT
  } state_t;

  localparam logic signed [31:0] ONE_Q24   = 32'sh0100_0000;
  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
  // Quotient bits of (|Q| << 24) / mu
  localparam int QUO_W = 56;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     load_write;
    logic     clr_power;
    logic     idx_clr;
    logic     diag_step;
    logic     ent_step;
    logic     k_step;
    logic     rate_rd_diag;
    logic     mu_clr;
    logic     mu_acc;
    logic     mu_commit;
    logic     div_load;
    logic     div_step;
    logic     act_write;
    logic     act_done;
    logic     mac_issue;
    logic     acc_clr;
    logic     mac_write;
    logic     pow_inc;
    logic     tab_rd;
    logic     res_load;
    res_sel_t res_sel;
    status_t  res_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic active;
    logic n_zero;
    logic n_over;
    logic idx_ok;
    logic col_ok;
    logic need_pow;
    logic pow_last;
    logic diag_last;
    logic ent_last;
    logic k_last;
    logic div_last;
    logic mu_zero;
    logic r_neg;
    logic mac_busy;
  } dp_stat_t;

endpackage

### design/uniformized_matrix_power_engine.sv
// Top level of the uniformized matrix power engine.
//
//  channel   signals                                    handshake
//  request   command row col power_index load_value     start & !busy
//  result    result_value status                        done, one cycle
//
// A load is accepted, decoded and written, then done is registered. A query on
// an active block with its power already in the table reads the table and
// registers the answer. Activation finds mu over the diagonal and then fills R
// one entry per divide on the bit-serial divider (56 steps). Each new power is
// computed on the single multiply-accumulate unit. Reset is synchronous and
// clears control state and the uniformization rate; the receiver cannot stall,
// so done lasts exactly one cycle.
module uniformized_matrix_power_engine import umpe_pkg::*; #(
  parameter int NSTATE    = 4,
  parameter int MAX_POWER = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic [7:0]         power_index,
  input  logic signed [31:0] load_value,
  output logic               done,
  output logic signed [31:0] result_value,
  output logic [1:0]         status
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  // Controller
  umpe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath
  umpe_dp #(.NSTATE(NSTATE), .MAX_POWER(MAX_POWER)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (command),
    .row          (row),
    .col          (col),
    .power_index  (power_index),
    .load_value   (load_value),
    .result_value (result_value),
    .status       (status),
    .done         (done)
  );

endmodule

### design/umpe_ram.sv
// Generic simple dual-port RAM with registered read.
module umpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/umpe_ctrl.sv
// Sequencer for loads, activation, lazy power products and answers.
module umpe_ctrl import umpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t st,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.cmd == CMD_LOAD_RATE || st.cmd == CMD_LOAD_STAT) begin
          cmd.load_write = 1'b1;
          cmd.clr_power  = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_OK;
          state_next     = S_IDLE;
        end else if (st.active) begin
          state_next = S_ANSWER;
        end else begin
          cmd.mu_clr  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_MU_RD;
        end
      end
      // mu = max |Q(i,i)|
      S_MU_RD: begin
        cmd.rate_rd_diag = 1'b1;
        state_next       = S_MU_ACC;
      end
      S_MU_ACC: begin
        cmd.mu_acc    = 1'b1;
        cmd.diag_step = 1'b1;
        state_next    = st.diag_last ? S_MU_END : S_MU_RD;
      end
      S_MU_END: begin
        cmd.mu_commit = 1'b1;
        if (st.mu_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_ZERO_MU;
          state_next     = S_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_DIV_RD;
        end
      end
      // R = I + Q/mu, one entry per divide
      S_DIV_RD: begin
        state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_DIV_END;
        end
      end
      S_DIV_END: begin
        if (st.r_neg) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_NEG_PROB;
          state_next     = S_IDLE;
        end else begin
          cmd.act_write = 1'b1;
          cmd.ent_step  = 1'b1;
          if (st.ent_last) begin
            cmd.act_done = 1'b1;
            state_next   = S_ANSWER;
          end else begin
            state_next = S_DIV_RD;
          end
        end
      end
      S_ANSWER: begin
        cmd.res_status = ST_OK;
        if (st.cmd == CMD_QUERY_MU) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MU;
          state_next   = S_IDLE;
        end else if (st.n_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_UNIT;
          state_next   = S_IDLE;
        end else if (st.n_over) begin
          if (st.col_ok) begin
            state_next = S_STAT_WAIT;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            state_next   = S_IDLE;
          end
        end else if (!st.idx_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_next   = S_IDLE;
        end else if (st.need_pow) begin
          cmd.idx_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          state_next  = S_MAC_RUN;
        end else begin
          cmd.tab_rd = 1'b1;
          state_next = S_TAB_WAIT;
        end
      end
      // Dot product of a row of R^(n-1) with a column of R
      S_MAC_RUN: begin
        cmd.mac_issue = 1'b1;
        cmd.k_step    = 1'b1;
        if (st.k_last) begin
          state_next = S_MAC_DRAIN;
        end
      end
      S_MAC_DRAIN: begin
        if (!st.mac_busy) begin
          cmd.mac_write = 1'b1;
          cmd.acc_clr   = 1'b1;
          cmd.ent_step  = 1'b1;
          if (st.ent_last) begin
            cmd.pow_inc = 1'b1;
            state_next  = st.pow_last ? S_ANSWER : S_MAC_RUN;
          end else begin
            state_next = S_MAC_RUN;
          end
        end
      end
      S_STAT_WAIT: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_STAT;
        cmd.res_status = ST_OK;
        state_next     = S_IDLE;
      end
      S_TAB_WAIT: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_TAB;
        cmd.res_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/umpe_dp.sv
// Datapath: matrix stores, divider, multiply-accumulate and result register.
module umpe_dp import umpe_pkg::*; #(
  parameter int NSTATE    = 4,
  parameter int MAX_POWER = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           st,
  input  logic [1:0]         command,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic [7:0]         power_index,
  input  logic signed [31:0] load_value,
  output logic signed [31:0] result_value,
  output logic [1:0]         status,
  output logic               done
);

  localparam int MS = NSTATE * NSTATE;
  localparam int IW = $clog2(NSTATE);
  localparam int AW = $clog2(MS);
  localparam int TD = MAX_POWER * MS;
  localparam int TW = $clog2(TD);
  localparam int PW = $clog2(MAX_POWER + 1);
  localparam logic [IW-1:0] LAST = IW'(NSTATE - 1);

  // Captured request
  cmd_t               cmd_q;
  logic [1:0]         row_q, col_q;
  logic [7:0]         n_q;
  logic signed [31:0] val_q;

  logic [IW-1:0] i, j, k;
  logic [PW-1:0] computed;
  logic          active;
  logic [31:0]   mu, uniform_rate;

  logic [31:0]   rem;
  logic [QUO_W-1:0] quo;
  logic          div_neg, div_diag;
  logic [5:0]    div_cnt;

  logic          v1, v2;
  logic [63:0]   prod, acc;

  logic signed [31:0] rate_dout, stat_dout, r_dout_s, tab_dout_s;
  logic [31:0]   r_dout, tab_dout;
  logic          idx_ok, col_ok;
  logic [AW-1:0] addr_rc, addr_ij, addr_ii, addr_ik, addr_kj;

  assign idx_ok  = (int'(row_q) < NSTATE) && (int'(col_q) < NSTATE);
  assign col_ok  = (int'(col_q) < NSTATE);
  assign addr_rc = AW'(int'(row_q) * NSTATE + int'(col_q));
  assign addr_ij = AW'(int'(i) * NSTATE + int'(j));
  assign addr_ii = AW'(int'(i) * NSTATE + int'(i));
  assign addr_ik = AW'(int'(i) * NSTATE + int'(k));
  assign addr_kj = AW'(int'(k) * NSTATE + int'(j));

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q <= cmd_t'(command);
      row_q <= row;
      col_q <= col;
      n_q   <= power_index;
      val_q <= load_value;
    end
  end

  // Index counters
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      if (cmd.diag_step) begin
        i <= (i == LAST) ? '0 : i + 1'b1;
      end
      if (cmd.ent_step) begin
        if (j == LAST) begin
          j <= '0;
          i <= (i == LAST) ? '0 : i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end
      if (cmd.k_step) begin
        k <= (k == LAST) ? '0 : k + 1'b1;
      end
    end
  end

  // Activation state and uniformization rate
  logic [31:0] abs_d;
  always_comb begin
    if (rate_dout == INT32_MIN) begin
      abs_d = INT32_MAX;
    end else if (rate_dout < 0) begin
      abs_d = 32'(-rate_dout);
    end else begin
      abs_d = rate_dout;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      computed     <= '0;
      uniform_rate <= ONE_Q24;
    end else begin
      if (cmd.clr_power) begin
        active   <= 1'b0;
        computed <= '0;
      end else if (cmd.act_done) begin
        active   <= 1'b1;
        computed <= PW'(1);
      end else if (cmd.pow_inc) begin
        computed <= computed + 1'b1;
      end
      if (cmd.mu_commit) begin
        uniform_rate <= mu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mu_clr) begin
      mu <= '0;
    end else if (cmd.mu_acc && abs_d > mu) begin
      mu <= abs_d;
    end
  end

  function automatic logic [31:0] abs_q(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : v;
    return r;
  endfunction

  // Restoring divider, one quotient bit per cycle
  logic [32:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem, quo[QUO_W-1]};
  assign ge     = (rem_sh >= {1'b0, mu});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem      <= '0;
      quo      <= {abs_q(rate_dout), 24'b0};
      div_neg  <= rate_dout[31];
      div_diag <= (i == j);
      div_cnt  <= 6'(QUO_W - 1);
    end else if (cmd.div_step) begin
      rem     <= ge ? 32'(rem_sh - {1'b0, mu}) : rem_sh[31:0];
      quo     <= {quo[QUO_W-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Signed quotient plus identity, saturated
  logic signed [QUO_W+1:0] r_wide;
  logic signed [31:0]      r_val;
  always_comb begin
    r_wide = div_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    if (div_diag) begin
      r_wide = r_wide + (QUO_W+2)'(ONE_Q24);
    end
    if (r_wide > (QUO_W+2)'(INT32_MAX)) begin
      r_val = INT32_MAX;
    end else if (r_wide < -$signed((QUO_W+2)'(33'h1_0000_0000 >> 1))) begin
      r_val = INT32_MIN;
    end else begin
      r_val = r_wide[31:0];
    end
  end

  // Multiply-accumulate pipeline: read, multiply, saturating add
  logic [64:0] acc_sum, rnd_sum;
  logic [40:0] rnd_sh;
  logic [31:0] mac_val;
  assign acc_sum = {1'b0, acc} + {1'b0, prod};
  assign rnd_sum = {1'b0, acc} + 65'(ONE_Q24 >>> 1);
  assign rnd_sh  = rnd_sum[64:24];
  assign mac_val = (rnd_sh > 41'(INT32_MAX)) ? INT32_MAX : rnd_sh[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= tab_dout * r_dout;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc_sum[64] ? '1 : acc_sum[63:0];
    end
  end

  // Stores
  logic          tab_we;
  logic [TW-1:0] tab_waddr, tab_raddr;
  logic [31:0]   tab_wdata;
  assign tab_we    = cmd.act_write || cmd.mac_write;
  assign tab_waddr = cmd.act_write ? TW'(int'(addr_ij))
                                   : TW'(int'(computed) * MS + int'(addr_ij));
  assign tab_wdata = cmd.act_write ? r_val : mac_val;
  assign tab_raddr = cmd.tab_rd ? TW'((int'(n_q) - 1) * MS + int'(addr_rc))
                                : TW'((int'(computed) - 1) * MS + int'(addr_ik));

  umpe_ram #(.WIDTH(32), .DEPTH(MS)) u_rate (
    .clk   (clk),
    .we    (cmd.load_write && cmd_q == CMD_LOAD_RATE && idx_ok),
    .waddr (addr_rc),
    .wdata (val_q),
    .raddr (cmd.rate_rd_diag ? addr_ii : addr_ij),
    .rdata (rate_dout)
  );

  umpe_ram #(.WIDTH(32), .DEPTH(NSTATE)) u_stat (
    .clk   (clk),
    .we    (cmd.load_write && cmd_q == CMD_LOAD_STAT && col_ok),
    .waddr (IW'(col_q)),
    .wdata (val_q),
    .raddr (IW'(col_q)),
    .rdata (stat_dout)
  );

  umpe_ram #(.WIDTH(32), .DEPTH(MS)) u_unif (
    .clk   (clk),
    .we    (cmd.act_write),
    .waddr (addr_ij),
    .wdata (r_val),
    .raddr (addr_kj),
    .rdata (r_dout_s)
  );

  umpe_ram #(.WIDTH(32), .DEPTH(TD)) u_pow (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_dout_s)
  );

  assign r_dout   = r_dout_s;
  assign tab_dout = tab_dout_s;

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_status;
      case (cmd.res_sel)
        RES_MU:   result_value <= uniform_rate;
        RES_UNIT: result_value <= (row_q == col_q) ? ONE_Q24 : '0;
        RES_STAT: result_value <= stat_dout;
        RES_TAB:  result_value <= tab_dout;
        default:  result_value <= '0;
      endcase
    end
  end

  // Status to controller
  always_comb begin
    st.cmd       = cmd_q;
    st.active    = active;
    st.n_zero    = (n_q == '0);
    st.n_over    = (int'(n_q) > MAX_POWER);
    st.idx_ok    = idx_ok;
    st.col_ok    = col_ok;
    st.need_pow  = (int'(n_q) > int'(computed));
    st.pow_last  = (int'(computed) + 1 >= int'(n_q));
    st.diag_last = (i == LAST);
    st.ent_last  = (i == LAST) && (j == LAST);
    st.k_last    = (k == LAST);
    st.div_last  = (div_cnt == '0);
    st.mu_zero   = (mu == '0);
    st.r_neg     = (r_wide < 0);
    st.mac_busy  = v1 || v2;
  end

endmodule

### design/umpe_checker.sv
// Port-level checks of the engine, bound to the top level.
module umpe_checker import umpe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] result_value,
  input logic [1:0]         status
);

  // A result only follows a request in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a request in progress");

  // An accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // An error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_value == '0))
    else $error("error result with nonzero value");

  // Status code stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NEG_PROB || status == ST_ZERO_MU))
    else $error("undefined status code");

endmodule

bind uniformized_matrix_power_engine umpe_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .result_value (result_value),
  .status       (status)
);

### verif/uniformized_matrix_power_engine_tb.sv
// Self-checking testbench of the uniformized matrix power engine.
`timescale 1ns / 100ps

module uniformized_matrix_power_engine_tb;
  import umpe_pkg::*;

  localparam int NST = 4;
  localparam int MAXP = 16;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 4000;
  localparam longint ONE = 64'sd16777216;

  typedef struct {
    cmd_t cmd;
    logic [1:0] row;
    logic [1:0] col;
    logic [7:0] n;
    logic signed [31:0] val;
  } request_t;

  typedef struct {
    logic signed [31:0] value;
    status_t st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] command = CMD_LOAD_RATE;
  logic [1:0] row = '0;
  logic [1:0] col = '0;
  logic [7:0] power_index = '0;
  logic signed [31:0] load_value = '0;
  logic busy;
  logic done;
  logic signed [31:0] result_value;
  logic [1:0] status;

  request_t request_q[$];
  answer_t answer_q[$];
  int err_cnt = 0;
  int hold = 0;
  int burst = 0;
  int cyc = 0;

  // Shadow of the engine state
  logic signed [31:0] rate_m[NST*NST];
  logic signed [31:0] stat_v[NST];
  logic signed [31:0] pow_tab[MAXP][NST*NST];
  int unsigned pow_cnt = 0;
  bit pow_on = 0;
  logic signed [31:0] mu_reg = 32'sh0100_0000;

  uniformized_matrix_power_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .row(row), .col(col), .power_index(power_index),
    .load_value(load_value), .done(done), .result_value(result_value),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Activation: mu and R = I + Q/mu
  function automatic status_t activate_chain();
    longint mu, d, v;
    if (pow_on) return ST_OK;
    mu = 0;
    for (int i = 0; i < NST; i++) begin
      d = rate_m[i*NST+i];
      if (d < 0) d = -d;
      if (d > 2147483647) d = 2147483647;
      if (d > mu) mu = d;
    end
    mu_reg = 32'(mu);
    if (mu == 0) return ST_ZERO_MU;
    for (int i = 0; i < NST; i++) begin
      for (int j = 0; j < NST; j++) begin
        v = (longint'(rate_m[i*NST+j]) * ONE) / mu;
        if (i == j) v += ONE;
        if (v > 2147483647) v = 2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        if (v < 0) return ST_NEG_PROB;
        pow_tab[0][i*NST+j] = 32'(v);
      end
    end
    pow_cnt = 1;
    pow_on = 1;
    return ST_OK;
  endfunction

  // Lazy powers R^n, rounded half up and saturated
  function automatic void extend_powers(int unsigned upto);
    bit [63:0] acc, p, r;
    for (int unsigned n = pow_cnt; n < upto && n < MAXP; n++) begin
      for (int i = 0; i < NST; i++) begin
        for (int j = 0; j < NST; j++) begin
          acc = '0;
          for (int k = 0; k < NST; k++) begin
            p = {32'd0, pow_tab[n-1][i*NST+k]} * {32'd0, pow_tab[0][k*NST+j]};
            if (acc > ~64'd0 - p) acc = ~64'd0;
            else acc += p;
          end
          if (acc > ~64'd0 - 64'd8388608) r = ~64'd0 >> 24;
          else r = (acc + 64'd8388608) >> 24;
          if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
          pow_tab[n][i*NST+j] = r[31:0];
        end
      end
    end
    if (upto > pow_cnt) pow_cnt = upto;
  endfunction

  function automatic answer_t predict_answer(request_t rq);
    answer_t a;
    a.value = '0;
    a.st = ST_OK;
    if (rq.cmd == CMD_LOAD_RATE || rq.cmd == CMD_LOAD_STAT) begin
      pow_on = 0;
      pow_cnt = 0;
      if (rq.cmd == CMD_LOAD_RATE) rate_m[rq.row*NST+rq.col] = rq.val;
      else stat_v[rq.col] = rq.val;
    end else begin
      a.st = activate_chain();
      if (a.st == ST_OK) begin
        if (rq.cmd == CMD_QUERY_MU) a.value = mu_reg;
        else if (rq.n == 0) a.value = (rq.row == rq.col) ? 32'sh0100_0000 : '0;
        else if (rq.n > MAXP) a.value = stat_v[rq.col];
        else begin
          if (rq.n > pow_cnt) extend_powers(rq.n);
          a.value = pow_tab[rq.n-1][rq.row*NST+rq.col];
        end
      end
    end
    return a;
  endfunction

  // Idle gap before the next request: mostly short, a few long, some bursts
  function automatic int next_gap();
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_req(cmd_t c, int r, int cl, int n, logic signed [31:0] v);
    request_t rq;
    rq.cmd = c;
    rq.row = r[1:0];
    rq.col = cl[1:0];
    rq.n = n[7:0];
    rq.val = v;
    request_q.push_back(rq);
  endfunction

  function automatic void push_query();
    int n;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) n = $urandom_range(0, 17);
    else if (r < 9) n = $urandom_range(1, 4);
    else n = $urandom_range(17, 255);
    if ($urandom_range(0, 5) == 0) push_req(CMD_QUERY_MU, $urandom_range(0, 3),
                                            $urandom_range(0, 3), n, $urandom);
    else push_req(CMD_QUERY_POW, $urandom_range(0, 3), $urandom_range(0, 3), n, $urandom);
  endfunction

  // One scenario: a matrix load of some kind followed by queries
  function automatic void push_session();
    int kind;
    int sum;
    int off;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // zero uniformization rate
      for (int i = 0; i < NST; i++) push_req(CMD_LOAD_RATE, i, i, 0, '0);
    end else if (kind == 1) begin
      // negative rate at a random entry; off the diagonal it gives a negative entry in R
      push_req(CMD_LOAD_RATE, 0, 0, 0, -32'sd16777216);
      push_req(CMD_LOAD_RATE, $urandom_range(0, 3), $urandom_range(0, 3), 0,
               -$signed(32'($urandom_range(1, 32'h0fff_ffff))));
    end else if (kind == 2) begin
      // raw values over the whole range
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 3) == 0)
          push_req(CMD_LOAD_STAT, $urandom_range(0, 3), $urandom_range(0, 3), 0, $urandom);
        else
          push_req(CMD_LOAD_RATE, $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 255),
                   $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : $signed($urandom));
      end
    end else begin
      // mostly well-formed generator with random content
      for (int i = 0; i < NST; i++) begin
        sum = 0;
        for (int j = 0; j < NST; j++) begin
          if (j != i) begin
            off = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32'h0400_0000);
            sum += off;
            push_req(CMD_LOAD_RATE, i, j, $urandom_range(0, 255), off);
          end
        end
        if ($urandom_range(0, 4) == 0) sum += $urandom_range(0, 32'h0100_0000);
        push_req(CMD_LOAD_RATE, i, i, $urandom_range(0, 255),
                 $urandom_range(0, 6) == 0 ? sum : -sum);
      end
      if ($urandom_range(0, 1) == 0)
        push_req(CMD_LOAD_STAT, 0, $urandom_range(0, 3), 0, $urandom);
    end
    for (int q = $urandom_range(2, 8); q > 0; q--) push_query();
  endfunction

  // Driver
  always @(posedge clk) begin
    int h;
    request_t rq;
    h = hold;
    if (rst) begin
      start <= 1'b0;
      h = 0;
    end else begin
      if (start && !busy) begin
        rq.cmd = cmd_t'(command);
        rq.row = row;
        rq.col = col;
        rq.n = power_index;
        rq.val = load_value;
        answer_q.push_back(predict_answer(rq));
        h = next_gap();
      end
      if (!start || !busy) begin
        if (h > 0) begin
          start <= 1'b0;
          h--;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          command <= rq.cmd;
          row <= rq.row;
          col <= rq.col;
          power_index <= rq.n;
          load_value <= rq.val;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
    hold <= h;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Monitor
  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", result_value, '0);
      end else begin
        a = answer_q.pop_front();
        if (result_value !== a.value) report_mismatch("result_value", result_value, a.value);
        if (status !== a.st) report_mismatch("status", 32'(status), 32'(a.st));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    // directed: fill every entry, then the query corner cases
    for (int i = 0; i < NST; i++)
      for (int j = 0; j < NST; j++)
        push_req(CMD_LOAD_RATE, i, j, 255,
                 i == j ? -32'sd50331648 : 32'sd16777216);
    push_req(CMD_LOAD_STAT, 3, 0, 0, 32'sh7fff_ffff);
    push_req(CMD_LOAD_STAT, 0, 1, 0, 32'sh8000_0000);
    push_req(CMD_LOAD_STAT, 0, 2, 0, 32'sh0040_0000);
    push_req(CMD_LOAD_STAT, 0, 3, 0, '0);
    push_req(CMD_QUERY_MU, 0, 0, 0, '0);
    push_req(CMD_QUERY_POW, 2, 2, 0, '1);
    push_req(CMD_QUERY_POW, 1, 3, 0, '0);
    push_req(CMD_QUERY_POW, 3, 0, 1, '0);
    push_req(CMD_QUERY_POW, 3, 3, 16, '0);
    push_req(CMD_QUERY_POW, 2, 1, 17, '0);
    push_req(CMD_QUERY_POW, 1, 0, 255, '0);
    while (request_q.size() < 500) push_session();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (request_q.size() > 0 || start || answer_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && answer_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
design/umpe_pkg.sv
design/umpe_ram.sv
design/umpe_ctrl.sv
design/umpe_dp.sv
design/uniformized_matrix_power_engine.sv
design/umpe_checker.sv
verif/uniformized_matrix_power_engine_tb.sv
